>>> rtl/core/oidem_pkg.sv
// shared constants and types for the object id edge mask unit
package oidem_pkg;

	// id and geometry widths
	localparam int ID_BITS    = 32;
	localparam int LINE_DEPTH = 1024;
	localparam int COL_BITS   = 10;
	localparam int WIDTH_BITS = 11;
	localparam int ROW_BITS   = 16;

	localparam logic [ID_BITS-1:0] ID_MASK = {ID_BITS{1'b1}};

	// packed rgba, r in the low byte
	localparam logic [31:0] COLOR_WHITE = 32'hFFFF_FFFF;
	localparam logic [31:0] COLOR_BLACK = 32'hFF00_0000;

	// result queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = 2;
	localparam int QCNT_BITS   = 3;

	// register indexes on the config port
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_INVERT_MASK  = 2'd2;

	// input kinds
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	// line store read request from the front part
	typedef struct packed {
		logic                en;
		logic [COL_BITS-1:0] addr;
	} rd_req_t;

	// classified item handed from front to back
	typedef struct packed {
		logic                valid;
		logic [ID_BITS-1:0]  id;
		logic [COL_BITS-1:0] col;
		logic                emit;
		logic                left_ok;
		logic                right_ok;
		logic                top_ok;
		logic                bot_ok;
		logic                last;
	} s1_item_t;

	// one result word
	typedef struct packed {
		logic [31:0] color;
		logic        last;
	} result_t;

endpackage

>>> rtl/core/oidem_ram.sv
// generic single write port, single read port ram with registered read
module oidem_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/core/oidem_front.sv
// front part: accepts words, classifies pixel and drain steps, tracks raster position
module oidem_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [31:0]                       s_axis_tdata,  // object_id
	input  logic                              s_axis_tuser,  // req_type
	input  logic [oidem_pkg::WIDTH_BITS-1:0]  eff_width,
	input  logic [oidem_pkg::ROW_BITS-1:0]    eff_height,
	input  logic                              restart,
	input  logic [oidem_pkg::QCNT_BITS-1:0]   q_count,
	output oidem_pkg::rd_req_t                rd_req,
	output oidem_pkg::s1_item_t               item_s1
);
	import oidem_pkg::*;

	logic [COL_BITS-1:0] in_col_q;
	logic [ROW_BITS:0]   in_row_q;
	logic [COL_BITS-1:0] out_col_q;
	logic [ROW_BITS-1:0] out_row_q;

	logic                fire;
	logic                draining;
	logic                step;
	logic                emit;
	logic                in_wrap;
	logic                out_wrap;
	logic                out_bot;
	logic                last;
	logic [QCNT_BITS-1:0] pending;
	logic [ID_BITS-1:0]  id_val;

	// room in the queue for this word and the one in flight
	always_comb begin
		pending       = q_count + QCNT_BITS'(item_s1.valid & item_s1.emit);
		s_axis_tready = (pending < QCNT_BITS'(QUEUE_DEPTH));
	end

	// classify the word
	always_comb begin
		fire     = s_axis_tvalid & s_axis_tready;
		draining = (in_row_q >= {1'b0, eff_height});
		step     = fire & ((s_axis_tuser == REQ_PIXEL) | draining);
		id_val   = draining ? ID_MASK : s_axis_tdata[ID_BITS-1:0];
		emit     = (in_row_q >= (ROW_BITS+1)'(2))
			| ((in_row_q == (ROW_BITS+1)'(1)) & (in_col_q != '0));
		in_wrap  = (({1'b0, in_col_q} + WIDTH_BITS'(1)) >= eff_width);
		out_wrap = (({1'b0, out_col_q} + WIDTH_BITS'(1)) >= eff_width);
		out_bot  = (({1'b0, out_row_q} + (ROW_BITS+1)'(1)) >= {1'b0, eff_height});
		last     = out_bot & out_wrap;
	end

	// line store read at the input column
	assign rd_req.en   = step;
	assign rd_req.addr = in_col_q;

	// raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (restart || (step && emit && last)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (step) begin
			if (in_wrap) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + (ROW_BITS+1)'(1);
			end else begin
				in_col_q <= in_col_q + COL_BITS'(1);
			end
			if (emit) begin
				if (out_wrap) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + ROW_BITS'(1);
				end else begin
					out_col_q <= out_col_q + COL_BITS'(1);
				end
			end
		end
	end

	// hand-off register to the back part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s1 <= '0;
		end else begin
			item_s1.valid    <= step;
			item_s1.id       <= id_val;
			item_s1.col      <= in_col_q;
			item_s1.emit     <= emit;
			item_s1.left_ok  <= (out_col_q != '0);
			item_s1.right_ok <= ~out_wrap;
			item_s1.top_ok   <= (out_row_q != '0);
			item_s1.bot_ok   <= ~out_bot;
			item_s1.last     <= last;
		end
	end

endmodule

>>> rtl/core/oidem_back.sv
// back part: line store update, 3x3 id window and edge decision
module oidem_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  oidem_pkg::s1_item_t                  item_s1,
	input  oidem_pkg::rd_req_t                   rd_req,
	input  logic [2*oidem_pkg::ID_BITS-1:0]      ram_rdata,
	output logic                                 ram_wr_en,
	output logic [oidem_pkg::COL_BITS-1:0]       ram_wr_addr,
	output logic [2*oidem_pkg::ID_BITS-1:0]      ram_wr_data,
	input  logic                                 invert,
	input  logic                                 restart,
	output logic                                 push,
	output oidem_pkg::result_t                   push_data
);
	import oidem_pkg::*;

	logic [ID_BITS-1:0]   win_q [9];
	logic                 fwd_hit_q;
	logic [2*ID_BITS-1:0] fwd_data_q;

	logic [2*ID_BITS-1:0] line_word;
	logic [ID_BITS-1:0]   up_id;
	logic [ID_BITS-1:0]   mid_id;
	logic [ID_BITS-1:0]   center;
	logic                 edge_hit;
	logic                 is_edge;

	// line word is {middle, upper}; forward a write that the read just missed
	always_comb begin
		line_word   = fwd_hit_q ? fwd_data_q : ram_rdata;
		up_id       = line_word[ID_BITS-1:0];
		mid_id      = line_word[2*ID_BITS-1:ID_BITS];
		ram_wr_en   = item_s1.valid;
		ram_wr_addr = item_s1.col;
		ram_wr_data = {item_s1.id, mid_id};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else begin
			fwd_hit_q <= rd_req.en & ram_wr_en & (rd_req.addr == ram_wr_addr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= ram_wr_data;
	end

	// edge test on the window after this shift; centre is the middle of the column that was newest before this shift
	always_comb begin
		center   = win_q[7];
		edge_hit = 1'b0;
		if (item_s1.left_ok) begin
			edge_hit = edge_hit | ((win_q[4] != center)
				| (item_s1.top_ok & (win_q[3] != center))
				| (item_s1.bot_ok & (win_q[5] != center)));
		end
		edge_hit = edge_hit | (item_s1.top_ok & (win_q[6] != center))
			| (item_s1.bot_ok & (win_q[8] != center));
		if (item_s1.right_ok) begin
			edge_hit = edge_hit | ((mid_id != center)
				| (item_s1.top_ok & (up_id != center))
				| (item_s1.bot_ok & (item_s1.id != center)));
		end
		is_edge = edge_hit ^ invert;
		push    = item_s1.valid & item_s1.emit;
		if (center == ID_MASK) begin
			push_data.color = COLOR_BLACK;
		end else begin
			push_data.color = is_edge ? COLOR_WHITE : COLOR_BLACK;
		end
		push_data.last = item_s1.last;
	end

	// window shift, cleared at frame restart and after the last pixel of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (restart || (push && item_s1.last)) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (item_s1.valid) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= win_q[i+3];
			end
			win_q[6] <= up_id;
			win_q[7] <= mid_id;
			win_q[8] <= item_s1.id;
		end
	end

endmodule

>>> rtl/core/oidem_queue.sv
// short result queue between the back part and the output stream
module oidem_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  oidem_pkg::result_t              push_data,
	output logic [oidem_pkg::QCNT_BITS-1:0] count,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [31:0]                     m_axis_tdata,  // pixel_color
	output logic                            m_axis_tlast   // frame_last
);
	import oidem_pkg::*;

	result_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;
	logic                 pop;

	// head word to the output
	always_comb begin
		m_axis_tvalid = (count_q != '0);
		m_axis_tdata  = mem_q[rd_ptr_q].color;
		m_axis_tlast  = mem_q[rd_ptr_q].last;
		pop           = m_axis_tvalid & m_axis_tready;
		count         = count_q;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			count_q <= count_q + QCNT_BITS'(push) - QCNT_BITS'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/core/object_id_edge_mask_unit.sv
// top level of the object id edge mask unit: config registers and the front, back and queue
// The unit takes one object id word per clock in raster order while the result queue has room,
// and gives one colour word per pixel: white on an id edge, black elsewhere (swapped by
// invert_mask), black for the all-ones id. The input rate is set by the single read port of
// the 1024 x 64 line store, read when a word is accepted and written back the next cycle.
// A pixel's result is produced by the word frame_width + 1 positions later, then goes
// through the edge logic into a 4-word result queue; send frame_width + 1 drain words
// (tuser high) after the last pixel to flush a frame. The line store has no clearing pass.
// Writing frame_width or frame_height restarts the frame; write config only while idle.
module object_id_edge_mask_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // object_id
	input  logic        s_axis_tuser,   // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // pixel_color
	output logic        m_axis_tlast,   // frame_last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import oidem_pkg::*;

	logic [WIDTH_BITS-1:0] frame_width_q;
	logic [ROW_BITS-1:0]   frame_height_q;
	logic                  invert_mask_q;
	logic [WIDTH_BITS-1:0] eff_width;
	logic [ROW_BITS-1:0]   eff_height;
	logic                  cfg_wr;
	logic                  restart;

	rd_req_t               rd_req;
	s1_item_t              item_s1;
	logic [2*ID_BITS-1:0]  ram_rdata;
	logic                  ram_wr_en;
	logic [COL_BITS-1:0]   ram_wr_addr;
	logic [2*ID_BITS-1:0]  ram_wr_data;
	logic                  push;
	result_t               push_data;
	logic [QCNT_BITS-1:0]  q_count;

	// config write decode
	always_comb begin
		pready  = 1'b1;
		cfg_wr  = psel & penable & pwrite & pready;
		restart = cfg_wr & ((paddr[3:2] == REG_FRAME_WIDTH) | (paddr[3:2] == REG_FRAME_HEIGHT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= WIDTH_BITS'(640);
			frame_height_q <= ROW_BITS'(480);
			invert_mask_q  <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_FRAME_WIDTH: begin
					frame_width_q <= pwdata[WIDTH_BITS-1:0];
				end
				REG_FRAME_HEIGHT: begin
					frame_height_q <= pwdata[ROW_BITS-1:0];
				end
				REG_INVERT_MASK: begin
					invert_mask_q <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr[3:2])
			REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
			REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
			REG_INVERT_MASK:  prdata = 32'(invert_mask_q);
			default:          prdata = '0;
		endcase
	end

	// effective geometry: zero acts as one, width capped at the line store depth
	always_comb begin
		if (frame_width_q == '0) begin
			eff_width = WIDTH_BITS'(1);
		end else if (frame_width_q > WIDTH_BITS'(LINE_DEPTH)) begin
			eff_width = WIDTH_BITS'(LINE_DEPTH);
		end else begin
			eff_width = frame_width_q;
		end
		eff_height = (frame_height_q == '0) ? ROW_BITS'(1) : frame_height_q;
	end

	oidem_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.eff_width     (eff_width),
		.eff_height    (eff_height),
		.restart       (restart),
		.q_count       (q_count),
		.rd_req        (rd_req),
		.item_s1       (item_s1)
	);

	// upper and middle line stores share one word per column
	oidem_ram #(
		.WIDTH (2*ID_BITS),
		.DEPTH (LINE_DEPTH)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (rd_req.en),
		.rd_addr (rd_req.addr),
		.rd_data (ram_rdata)
	);

	oidem_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_s1     (item_s1),
		.rd_req      (rd_req),
		.ram_rdata   (ram_rdata),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.invert      (invert_mask_q),
		.restart     (restart),
		.push        (push),
		.push_data   (push_data)
	);

	oidem_queue u_queue (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.push_data     (push_data),
		.count         (q_count),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

>>> sim/edge_mask_checker.sv
// checker for the object id edge mask unit: watches the buses, predicts colour words, compares
module edge_mask_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // object_id
	input  logic        s_tuser,   // req_type
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // pixel_color
	input  logic        m_tlast,   // frame_last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output int          outstanding,
	output int          fails
);
	timeunit 1ns;
	timeprecision 1ps;

	import oidem_pkg::*;

	// shadow of the line stores, window and raster counters
	logic [ID_BITS-1:0] upper_ids  [LINE_DEPTH];
	logic [ID_BITS-1:0] middle_ids [LINE_DEPTH];
	logic [ID_BITS-1:0] win_ids    [9];
	int unsigned in_col, in_row, out_col, out_row;

	// shadow of the config registers
	logic [WIDTH_BITS-1:0] frame_width;
	logic [ROW_BITS-1:0]   frame_height;
	logic                  invert;

	// colour words still owed by the unit, oldest first
	result_t colour_q [$];
	result_t want_word;

	function automatic int unsigned line_width();
		if (frame_width == 0)
			return 1;
		if (frame_width > LINE_DEPTH)
			return LINE_DEPTH;
		return frame_width;
	endfunction

	function automatic int unsigned line_count();
		return (frame_height == 0) ? 1 : frame_height;
	endfunction

	task automatic restart_frame();
		in_col  = 0;
		in_row  = 0;
		out_col = 0;
		out_row = 0;
		for (int k = 0; k < 9; k++)
			win_ids[k] = '0;
	endtask

	// advance the window by one accepted word and queue the colour it releases
	task automatic take_word(input logic kind, input logic [31:0] data);
		int unsigned w, h, c;
		logic              draining, emit, is_edge, skip;
		logic [ID_BITS-1:0] v, centre;
		result_t           r;
		w = line_width();
		h = line_count();
		draining = (in_row >= h);
		// drain before the frame is complete is ignored
		if (kind == REQ_DRAIN && !draining)
			return;
		// a pixel while draining counts as a drain step
		v = draining ? ID_MASK : data[ID_BITS-1:0];
		c = (in_col >= LINE_DEPTH) ? LINE_DEPTH - 1 : in_col;
		for (int k = 0; k < 3; k++) begin
			win_ids[k]     = win_ids[3 + k];
			win_ids[3 + k] = win_ids[6 + k];
		end
		win_ids[6]    = upper_ids[c];
		win_ids[7]    = middle_ids[c];
		win_ids[8]    = v;
		upper_ids[c]  = middle_ids[c];
		middle_ids[c] = v;
		emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
		in_col++;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (!emit)
			return;
		centre = win_ids[4];
		if (centre == ID_MASK) begin
			r.color = COLOR_BLACK;
		end else begin
			// compare against every neighbour that lies inside the frame
			is_edge = 1'b0;
			for (int dc = 0; dc < 3; dc++) begin
				for (int dr = 0; dr < 3; dr++) begin
					skip = (dc == 1 && dr == 1) || (dc == 0 && out_col == 0) ||
						(dc == 2 && out_col + 1 >= w) || (dr == 0 && out_row == 0) ||
						(dr == 2 && out_row + 1 >= h);
					if (!skip && win_ids[dc * 3 + dr] != centre)
						is_edge = 1'b1;
				end
			end
			if (invert)
				is_edge = !is_edge;
			r.color = is_edge ? COLOR_WHITE : COLOR_BLACK;
		end
		r.last = (out_row + 1 >= h) && (out_col + 1 >= w);
		colour_q.push_back(r);
		if (r.last) begin
			restart_frame();
		end else begin
			out_col++;
			if (out_col >= w) begin
				out_col = 0;
				out_row++;
			end
		end
	endtask

	task automatic note_mismatch(input string what, input logic [31:0] want,
		input logic [31:0] got);
		fails++;
		if (fails <= 10)
			$display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
	endtask

	// one pass per clock: results out first, then the word in, then register writes
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LINE_DEPTH; k++) begin
				upper_ids[k]  = '0;
				middle_ids[k] = '0;
			end
			frame_width  = 11'd640;
			frame_height = 16'd480;
			invert       = 1'b0;
			fails        = 0;
			restart_frame();
			colour_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (colour_q.size() == 0) begin
					note_mismatch("unexpected colour word", '0, m_tdata);
				end else begin
					want_word = colour_q.pop_front();
					if (m_tdata !== want_word.color)
						note_mismatch("pixel_color", want_word.color, m_tdata);
					if (m_tlast !== want_word.last)
						note_mismatch("frame_last", 32'(want_word.last), 32'(m_tlast));
				end
			end
			if (s_tvalid && s_tready)
				take_word(s_tuser, s_tdata);
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_FRAME_WIDTH: begin
						frame_width = pwdata[WIDTH_BITS-1:0];
						restart_frame();
					end
					REG_FRAME_HEIGHT: begin
						frame_height = pwdata[ROW_BITS-1:0];
						restart_frame();
					end
					REG_INVERT_MASK: begin
						invert = pwdata[0];
					end
					default: begin
					end
				endcase
			end
		end
		outstanding <= colour_q.size();
	end

endmodule

>>> sim/object_id_edge_mask_unit_tb.sv
// testbench top for the object id edge mask unit: clock, reset, stimulus and verdict
module object_id_edge_mask_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import oidem_pkg::*;

	localparam int QUIET_LIMIT = 4000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;   // object_id
	logic        s_axis_tuser = 1'b0; // req_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;        // pixel_color
	logic        m_axis_tlast;        // frame_last
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	logic        idle_on = 1'b1;
	int          outstanding;
	int          fails;
	int          quiet_cycles = 0;
	int unsigned pixels_sent = 0;

	object_id_edge_mask_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	edge_mask_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_axis_tvalid),
		.s_tready    (s_axis_tready),
		.s_tdata     (s_axis_tdata),
		.s_tuser     (s_axis_tuser),
		.m_tvalid    (m_axis_tvalid),
		.m_tready    (m_axis_tready),
		.m_tdata     (m_axis_tdata),
		.m_tlast     (m_axis_tlast),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.outstanding (outstanding),
		.fails       (fails)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// colour word sink with random back-pressure while idle_on is set
	always @(posedge clk) begin
		m_axis_tready <= idle_on ? ($urandom_range(0, 99) >= 25) : 1'b1;
	end

	// give up when no word moves on any bus for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("object_id_edge_mask_unit: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one id word on the input bus, with random gaps ahead of it while idle_on is set
	task automatic send_word(input logic kind, input logic [31:0] data);
		while (idle_on && $urandom_range(0, 99) < 25) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= data;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// setup and access phase, then the bus is left quiet
	task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// let every owed colour word out and the pipeline settle
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// configure, stream npix ids with a few early drains, flush if the frame is complete
	task automatic run_frame(input int unsigned w, input int unsigned h, input logic inv,
		input int unsigned npix);
		int unsigned weff, heff, col, shift, i;
		int          roll;
		logic [31:0] pal [4];
		logic [31:0] id;
		weff = (w == 0) ? 1 : ((w > LINE_DEPTH) ? LINE_DEPTH : w);
		heff = (h == 0) ? 1 : h;
		if (npix > weff * heff)
			npix = weff * heff;
		wait_idle();
		cfg_write(REG_FRAME_WIDTH, w);
		cfg_write(REG_FRAME_HEIGHT, h);
		cfg_write(REG_INVERT_MASK, 32'(inv));
		for (i = 0; i < 4; i++)
			pal[i] = ($urandom_range(0, 3) == 0) ? ID_MASK : $urandom();
		shift = $urandom_range(0, 3);
		id    = pal[0];
		col   = 0;
		for (i = 0; i < npix; i++) begin
			if ($urandom_range(0, 99) < 8)
				send_word(REQ_DRAIN, $urandom());
			// mostly column bands of a small id set, so flat areas and edges both occur
			roll = $urandom_range(0, 99);
			if (roll < 55)
				id = pal[(col >> shift) & 3];
			else if (roll < 75)
				id = pal[$urandom_range(0, 3)];
			else if (roll >= 90)
				id = $urandom();
			send_word(REQ_PIXEL, id);
			col = (col + 1 == weff) ? 0 : col + 1;
		end
		// flush: one row plus one word, some of them late pixels
		if (npix == weff * heff) begin
			for (i = 0; i <= weff; i++) begin
				if ($urandom_range(0, 99) < 20)
					send_word(REQ_PIXEL, $urandom());
				else
					send_word(REQ_DRAIN, $urandom());
			end
		end
		pixels_sent += npix;
	endtask

	initial begin : stimulus
		logic [31:0] directed_ids [12];
		int unsigned w, h, n;
		directed_ids = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h0000_0005, 32'h0000_0005, 32'hFFFF_FFFE,
			32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed 4 x 3 frame with early drains, an all-ones id and a late pixel
		cfg_write(REG_FRAME_WIDTH, 4);
		cfg_write(REG_FRAME_HEIGHT, 3);
		cfg_write(REG_INVERT_MASK, 0);
		send_word(REQ_DRAIN, 32'hFFFF_FFFF);
		for (int i = 0; i < 12; i++) begin
			if (i == 6)
				send_word(REQ_DRAIN, 32'h0000_0000);
			send_word(REQ_PIXEL, directed_ids[i]);
		end
		send_word(REQ_DRAIN, 32'h0000_0000);
		send_word(REQ_PIXEL, 32'h1234_5678);
		repeat (3) send_word(REQ_DRAIN, 32'hFFFF_FFFF);

		// single pixel frames with invert: lone id, then no object
		wait_idle();
		cfg_write(REG_FRAME_WIDTH, 1);
		cfg_write(REG_FRAME_HEIGHT, 1);
		cfg_write(REG_INVERT_MASK, 1);
		send_word(REQ_PIXEL, 32'h0000_0000);
		repeat (2) send_word(REQ_DRAIN, 32'h0000_0000);
		send_word(REQ_PIXEL, 32'hFFFF_FFFF);
		repeat (2) send_word(REQ_DRAIN, 32'h0000_0000);

		// geometry extremes as short frames, some of them partial, a partial frame of the tallest
		// height and a stall-free stretch
		run_frame(1024, 2, 0, 8);
		run_frame(2047, 1, 1, 8);
		run_frame(0, 3, 0, 3);
		run_frame(5, 0, 1, 5);
		run_frame(3, 65535, 1, 60);
		run_frame(1, 1, 0, 1);
		idle_on <= 1'b0;
		run_frame(8, 6, 0, 48);
		run_frame(8, 6, 1, 48);
		idle_on <= 1'b1;

		// random frames, mostly small, some cut short by the next geometry write
		while (pixels_sent < 400) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
			h = $urandom_range(1, 8);
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w * h) : w * h;
			run_frame(w, h, 1'($urandom_range(0, 1)), n);
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("object_id_edge_mask_unit: match");
		else
			$display("object_id_edge_mask_unit: mismatch");
		$finish;
	end

endmodule

>>> files.f
rtl/core/oidem_pkg.sv
rtl/core/oidem_ram.sv
rtl/core/oidem_front.sv
rtl/core/oidem_back.sv
rtl/core/oidem_queue.sv
rtl/core/object_id_edge_mask_unit.sv
sim/edge_mask_checker.sv
sim/object_id_edge_mask_unit_tb.sv
